@@ sv/rvu_pkg.sv @@
`default_nettype none

package rvu_pkg;

    localparam int VEC_W      = 16;
    localparam int ETA_W      = 16;
    localparam int PERP_W     = 25;
    localparam int SUM_W      = 42;
    localparam int RED_W      = 32;
    localparam int K_W        = 4;
    localparam int SQRT_OUT_W = 32;
    localparam int SQRT_IN_W  = 2 * SQRT_OUT_W;
    localparam int SQRT_LAT   = SQRT_OUT_W;
    localparam int S_W        = 24;           // root of a value below 2^48
    localparam int DIV_BITS   = 15;
    localparam int REM_W      = 47;
    localparam int DEN_W      = SQRT_OUT_W + 1;
    localparam int ONE_Q28    = 2**28;        // 1.0 in Q.28
    localparam int RED_LOG2   = 30;           // reduced sum stays at or below 2^30 in magnitude

    typedef logic [2:0][VEC_W-1:0]  t_vec3;
    typedef logic [2:0][PERP_W-1:0] t_perp3;
    typedef logic [2:0][RED_W-1:0]  t_red3;

    typedef struct packed {
        t_perp3 perp;
        t_vec3  norm;
    } t_front_sb;

    typedef struct packed {
        t_red3 red;
        logic  degen;
    } t_back_sb;

endpackage

`default_nettype wire

@@ sv/rvu_if.sv @@
`default_nettype none

interface rvu_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_y;
    logic signed [15:0] dir_z;
    logic signed [15:0] norm_x;
    logic signed [15:0] norm_y;
    logic signed [15:0] norm_z;
    logic        [15:0] eta_ratio;

    modport source (output valid, dir_x, dir_y, dir_z, norm_x, norm_y, norm_z, eta_ratio,
                    input ready);
    modport sink (input valid, dir_x, dir_y, dir_z, norm_x, norm_y, norm_z, eta_ratio,
                  output ready);
endinterface

interface rvu_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] out_x;
    logic signed [15:0] out_y;
    logic signed [15:0] out_z;
    logic               degenerate;

    modport source (output valid, out_x, out_y, out_z, degenerate, input ready);
    modport sink (input valid, out_x, out_y, out_z, degenerate, output ready);
endinterface

`default_nettype wire

@@ sv/rvu_sqrt.sv @@
`default_nettype none

// Pipelined integer square root, one root bit per stage, floor result.
module rvu_sqrt (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_ce,
    input  logic                            i_valid,
    input  logic [rvu_pkg::SQRT_IN_W-1:0]   i_val,
    output logic                            o_valid,
    output logic [rvu_pkg::SQRT_OUT_W-1:0]  o_root
);
    import rvu_pkg::*;

    logic [SQRT_LAT-1:0]   r_vld;
    logic [SQRT_IN_W-1:0]  r_rem  [0:SQRT_LAT-1];
    logic [SQRT_OUT_W-1:0] r_root [0:SQRT_LAT-1];
    logic [SQRT_IN_W-1:0]  p_rem  [0:SQRT_LAT-1];
    logic [SQRT_OUT_W-1:0] p_root [0:SQRT_LAT-1];
    logic [SQRT_IN_W-1:0]  n_rem  [0:SQRT_LAT-1];
    logic [SQRT_OUT_W-1:0] n_root [0:SQRT_LAT-1];
    logic [SQRT_IN_W-1:0]  trial  [0:SQRT_LAT-1];

    always_comb begin
        p_rem[0]  = i_val;
        p_root[0] = '0;
        for (int g = 1; g < SQRT_LAT; g++) begin
            p_rem[g]  = r_rem[g-1];
            p_root[g] = r_root[g-1];
        end
        // rem = v - root^2; test (root + 2^b)^2 <= v
        for (int g = 0; g < SQRT_LAT; g++) begin
            trial[g] = ({{(SQRT_IN_W-SQRT_OUT_W){1'b0}}, p_root[g]} << (SQRT_LAT - g))
                     | ({{(SQRT_IN_W-1){1'b0}}, 1'b1} << (2 * (SQRT_LAT - 1 - g)));
            if (p_rem[g] >= trial[g]) begin
                n_rem[g]  = p_rem[g] - trial[g];
                n_root[g] = p_root[g] | ({{(SQRT_OUT_W-1){1'b0}}, 1'b1} << (SQRT_LAT - 1 - g));
            end else begin
                n_rem[g]  = p_rem[g];
                n_root[g] = p_root[g];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_ce) begin
            r_vld <= {r_vld[SQRT_LAT-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            for (int g = 0; g < SQRT_LAT; g++) begin
                r_rem[g]  <= n_rem[g];
                r_root[g] <= n_root[g];
            end
        end
    end

    assign o_valid = r_vld[SQRT_LAT-1];
    assign o_root  = r_root[SQRT_LAT-1];

endmodule

`default_nettype wire

@@ sv/rvu_front.sv @@
`default_nettype none

// cos, perpendicular part and |1 - |perp|^2|, eight stages.
module rvu_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_ce,
    input  logic                           i_valid,
    input  rvu_pkg::t_vec3                 i_dir,
    input  rvu_pkg::t_vec3                 i_norm,
    input  logic [rvu_pkg::ETA_W-1:0]      i_eta,
    output logic                           o_valid,
    output logic [rvu_pkg::SQRT_IN_W-1:0]  o_mag,
    output rvu_pkg::t_front_sb             o_sb
);
    import rvu_pkg::*;

    logic [7:0] r_vld;

    logic signed [31:0]       r1_prod [0:2];
    logic signed [VEC_W-1:0]  r1_dir  [0:2];
    logic signed [VEC_W-1:0]  r1_norm [0:2];
    logic [ETA_W-1:0]         r1_eta;

    logic signed [33:0]       n2_dot, n2_neg, n2_cos;
    logic signed [33:0]       r2_cos;
    logic signed [VEC_W-1:0]  r2_dir  [0:2];
    logic signed [VEC_W-1:0]  r2_norm [0:2];
    logic [ETA_W-1:0]         r2_eta;

    logic signed [49:0]       r3_cn   [0:2];
    logic signed [VEC_W-1:0]  r3_dir  [0:2];
    logic signed [VEC_W-1:0]  r3_norm [0:2];
    logic [ETA_W-1:0]         r3_eta;

    logic signed [49:0]       n4_ts   [0:2];
    logic signed [35:0]       r4_t    [0:2];
    logic signed [VEC_W-1:0]  r4_norm [0:2];
    logic [ETA_W-1:0]         r4_eta;

    logic signed [52:0]       r5_et   [0:2];
    logic signed [VEC_W-1:0]  r5_norm [0:2];

    logic signed [PERP_W-1:0] r6_perp [0:2];
    logic signed [VEC_W-1:0]  r6_norm [0:2];

    logic signed [49:0]       n7_sq   [0:2];
    logic [46:0]              r7_sq   [0:2];
    logic signed [PERP_W-1:0] r7_perp [0:2];
    logic signed [VEC_W-1:0]  r7_norm [0:2];

    logic [47:0]              n8_len2, n8_mag;
    logic [47:0]              r8_mag;
    logic signed [PERP_W-1:0] r8_perp [0:2];
    logic signed [VEC_W-1:0]  r8_norm [0:2];

    always_comb begin
        n2_dot = 34'(r1_prod[0]) + 34'(r1_prod[1]) + 34'(r1_prod[2]);
        n2_neg = -n2_dot;
        n2_cos = (n2_neg > 34'(ONE_Q28)) ? 34'(ONE_Q28) : n2_neg;  // capped above only
        for (int i = 0; i < 3; i++) begin
            n4_ts[i] = (50'(r3_dir[i]) <<< 28) + r3_cn[i] + 50'(2**13);
            n7_sq[i] = 50'(r6_perp[i]) * 50'(r6_perp[i]);
        end
        n8_len2 = 48'(r7_sq[0]) + 48'(r7_sq[1]) + 48'(r7_sq[2]);
        n8_mag  = (n8_len2 > 48'(ONE_Q28)) ? n8_len2 - 48'(ONE_Q28)
                                           : 48'(ONE_Q28) - n8_len2;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_ce) begin
            r_vld <= {r_vld[6:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            for (int i = 0; i < 3; i++) begin
                r1_prod[i] <= 32'($signed(i_dir[i])) * 32'($signed(i_norm[i]));
                r1_dir[i]  <= $signed(i_dir[i]);
                r1_norm[i] <= $signed(i_norm[i]);

                r2_dir[i]  <= r1_dir[i];
                r2_norm[i] <= r1_norm[i];

                r3_cn[i]   <= 50'(r2_cos) * 50'(r2_norm[i]);
                r3_dir[i]  <= r2_dir[i];
                r3_norm[i] <= r2_norm[i];

                r4_t[i]    <= 36'(n4_ts[i] >>> 14);
                r4_norm[i] <= r3_norm[i];

                r5_et[i]   <= 53'($signed({1'b0, r4_eta})) * 53'(r4_t[i]);
                r5_norm[i] <= r4_norm[i];

                r6_perp[i] <= PERP_W'((r5_et[i] + 53'(2**25)) >>> 26);
                r6_norm[i] <= r5_norm[i];

                r7_sq[i]   <= 47'(n7_sq[i]);
                r7_perp[i] <= r6_perp[i];
                r7_norm[i] <= r6_norm[i];

                r8_perp[i] <= r7_perp[i];
                r8_norm[i] <= r7_norm[i];
            end
            r1_eta <= i_eta;
            r2_cos <= n2_cos;
            r2_eta <= r1_eta;
            r3_eta <= r2_eta;
            r4_eta <= r3_eta;
            r8_mag <= n8_mag;
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            o_sb.perp[i] = r8_perp[i];
            o_sb.norm[i] = r8_norm[i];
        end
    end

    assign o_valid = r_vld[7];
    assign o_mag   = SQRT_IN_W'(r8_mag);

endmodule

`default_nettype wire

@@ sv/rvu_back.sv @@
`default_nettype none

// Sum vector, zero test, range reduction and squared length, six stages.
module rvu_back (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_ce,
    input  logic                           i_valid,
    input  logic [rvu_pkg::SQRT_OUT_W-1:0] i_root,
    input  rvu_pkg::t_front_sb             i_sb,
    output logic                           o_valid,
    output logic [rvu_pkg::SQRT_IN_W-1:0]  o_l2,
    output rvu_pkg::t_back_sb              o_sb
);
    import rvu_pkg::*;

    logic [5:0] r_vld;

    logic signed [40:0]       r1_sn   [0:2];
    logic signed [PERP_W-1:0] r1_perp [0:2];

    logic signed [SUM_W-1:0]  r2_sum  [0:2];

    logic [SUM_W-1:0]         n3_mag  [0:2];
    logic [SUM_W-1:0]         n3_or;
    logic [K_W-1:0]           n3_k;
    logic signed [SUM_W-1:0]  r3_sum  [0:2];
    logic [K_W-1:0]           r3_k;
    logic                     r3_degen;

    logic [SUM_W:0]           n4_half;
    logic signed [RED_W-1:0]  r4_red  [0:2];
    logic                     r4_degen;

    logic signed [63:0]       n5_sq   [0:2];
    logic [60:0]              r5_sq   [0:2];
    logic signed [RED_W-1:0]  r5_red  [0:2];
    logic                     r5_degen;

    logic [SQRT_IN_W-1:0]     r6_l2;
    logic signed [RED_W-1:0]  r6_red  [0:2];
    logic                     r6_degen;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n3_mag[i] = r2_sum[i][SUM_W-1] ? SUM_W'(-r2_sum[i]) : SUM_W'(r2_sum[i]);
            n5_sq[i]  = 64'(r4_red[i]) * 64'(r4_red[i]);
        end
        // the OR of magnitudes has the msb of the largest one
        n3_or = n3_mag[0] | n3_mag[1] | n3_mag[2];
        n3_k  = '0;
        for (int j = 1; j <= SUM_W - RED_LOG2; j++) begin
            if (n3_or[RED_LOG2 - 1 + j]) begin
                n3_k = K_W'(j);
            end
        end
        n4_half = ({{SUM_W{1'b0}}, 1'b1} << r3_k) >> 1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_ce) begin
            r_vld <= {r_vld[4:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            for (int i = 0; i < 3; i++) begin
                r1_sn[i]   <= 41'($signed({1'b0, i_root[S_W-1:0]})) * 41'($signed(i_sb.norm[i]));
                r1_perp[i] <= $signed(i_sb.perp[i]);

                r2_sum[i]  <= (SUM_W'(r1_perp[i]) <<< 14) - SUM_W'(r1_sn[i]);

                r3_sum[i]  <= r2_sum[i];

                r4_red[i]  <= RED_W'((43'(r3_sum[i]) + $signed(n4_half)) >>> r3_k);

                r5_sq[i]   <= 61'(n5_sq[i]);
                r5_red[i]  <= r4_red[i];

                r6_red[i]  <= r5_red[i];
            end
            r3_k     <= n3_k;
            r3_degen <= (n3_or == '0);
            r4_degen <= r3_degen;
            r5_degen <= r4_degen;
            r6_l2    <= SQRT_IN_W'(r5_sq[0]) + SQRT_IN_W'(r5_sq[1]) + SQRT_IN_W'(r5_sq[2]);
            r6_degen <= r5_degen;
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            o_sb.red[i] = r6_red[i];
        end
        o_sb.degen = r6_degen;
    end

    assign o_valid = r_vld[5];
    assign o_l2    = r6_l2;

endmodule

`default_nettype wire

@@ sv/rvu_div.sv @@
`default_nettype none

// Three-lane restoring divider, one quotient bit per stage, then the
// output register. Quotient = (|red|*2^15 + len) / (2*len).
module rvu_div (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_ce,
    input  logic                           i_valid,
    input  logic [rvu_pkg::SQRT_OUT_W-1:0] i_len,
    input  rvu_pkg::t_back_sb              i_sb,
    output logic                           o_valid,
    output rvu_pkg::t_vec3                 o_vec,
    output logic                           o_degen
);
    import rvu_pkg::*;

    logic [DIV_BITS+1:0]   r_vld;

    logic [SQRT_OUT_W-1:0] n0_len;
    logic [RED_W-2:0]      n0_mag [0:2];

    logic [REM_W-1:0]      r_rem [0:DIV_BITS][0:2];
    logic [DIV_BITS-1:0]   r_quo [0:DIV_BITS][0:2];
    logic                  r_neg [0:DIV_BITS][0:2];
    logic [DEN_W-1:0]      r_den [0:DIV_BITS];
    logic                  r_dg  [0:DIV_BITS];

    logic [REM_W-1:0]      trial [1:DIV_BITS];
    logic [REM_W-1:0]      n_rem [1:DIV_BITS][0:2];
    logic [DIV_BITS-1:0]   n_quo [1:DIV_BITS][0:2];

    logic [VEC_W-1:0]      n_out [0:2];
    t_vec3                 r_out;
    logic                  r_out_dg;

    always_comb begin
        n0_len = (i_len == '0) ? SQRT_OUT_W'(1) : i_len;
        for (int i = 0; i < 3; i++) begin
            n0_mag[i] = i_sb.red[i][RED_W-1] ? (RED_W-1)'(-$signed(i_sb.red[i]))
                                             : (RED_W-1)'(i_sb.red[i]);
        end
        for (int g = 1; g <= DIV_BITS; g++) begin
            trial[g] = REM_W'(r_den[g-1]) << (DIV_BITS - g);
            for (int i = 0; i < 3; i++) begin
                if (r_rem[g-1][i] >= trial[g]) begin
                    n_rem[g][i] = r_rem[g-1][i] - trial[g];
                    n_quo[g][i] = r_quo[g-1][i]
                                | (DIV_BITS'(1) << (DIV_BITS - g));
                end else begin
                    n_rem[g][i] = r_rem[g-1][i];
                    n_quo[g][i] = r_quo[g-1][i];
                end
            end
        end
        for (int i = 0; i < 3; i++) begin
            if (r_dg[DIV_BITS]) begin
                n_out[i] = '0;
            end else if (r_neg[DIV_BITS][i]) begin
                n_out[i] = ~{1'b0, r_quo[DIV_BITS][i]} + VEC_W'(1);
            end else begin
                n_out[i] = {1'b0, r_quo[DIV_BITS][i]};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_ce) begin
            r_vld <= {r_vld[DIV_BITS:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            for (int i = 0; i < 3; i++) begin
                r_rem[0][i] <= (REM_W'(n0_mag[i]) << 15) + REM_W'(n0_len);
                r_quo[0][i] <= '0;
                r_neg[0][i] <= i_sb.red[i][RED_W-1];
            end
            r_den[0] <= {n0_len, 1'b0};
            r_dg[0]  <= i_sb.degen;
            for (int g = 1; g <= DIV_BITS; g++) begin
                for (int i = 0; i < 3; i++) begin
                    r_rem[g][i] <= n_rem[g][i];
                    r_quo[g][i] <= n_quo[g][i];
                    r_neg[g][i] <= r_neg[g-1][i];
                end
                r_den[g] <= r_den[g-1];
                r_dg[g]  <= r_dg[g-1];
            end
            for (int i = 0; i < 3; i++) begin
                r_out[i] <= n_out[i];
            end
            r_out_dg <= r_dg[DIV_BITS];
        end
    end

    assign o_valid = r_vld[DIV_BITS+1];
    assign o_vec   = r_out;
    assign o_degen = r_out_dg;

endmodule

`default_nettype wire

@@ sv/refract_vector_unit.sv @@
`default_nettype none

// Channel | Dir | Word
// i_in    | in  | dir_x/y/z, norm_x/y/z (Q2.14), eta_ratio (Q4.12)
// o_out   | out | out_x/y/z (Q2.14), degenerate
//
// One word accepted per cycle while not stalled. Stages: front 8, square
// root 32, back 6, square root 32, divider 16, plus the output register.
// The two 32-stage square root units and the 16-stage divider set depth.
// Reset clears only the valid bits. All stages advance together whenever
// the output register is empty or being taken, so a stall holds everything.
module refract_vector_unit (
    input  logic      i_clk,
    input  logic      i_rst_n,
    rvu_in_if.sink    i_in,
    rvu_out_if.source o_out
);
    import rvu_pkg::*;

    logic                  ce;
    t_vec3                 in_dir, in_norm;

    logic                  fr_valid;
    logic [SQRT_IN_W-1:0]  fr_mag;
    t_front_sb             fr_sb;

    logic                  s1_valid;
    logic [SQRT_OUT_W-1:0] s1_root;
    t_front_sb             r_sb1 [0:SQRT_LAT-1];

    logic                  bk_valid;
    logic [SQRT_IN_W-1:0]  bk_l2;
    t_back_sb              bk_sb;

    logic                  s2_valid;
    logic [SQRT_OUT_W-1:0] s2_root;
    t_back_sb              r_sb2 [0:SQRT_LAT-1];

    logic                  dv_valid;
    t_vec3                 dv_vec;
    logic                  dv_degen;

    assign ce         = !dv_valid || o_out.ready;
    assign i_in.ready = ce;

    assign in_dir  = {i_in.dir_z, i_in.dir_y, i_in.dir_x};
    assign in_norm = {i_in.norm_z, i_in.norm_y, i_in.norm_x};

    rvu_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (ce),
        .i_valid (i_in.valid),
        .i_dir   (in_dir),
        .i_norm  (in_norm),
        .i_eta   (i_in.eta_ratio),
        .o_valid (fr_valid),
        .o_mag   (fr_mag),
        .o_sb    (fr_sb)
    );

    rvu_sqrt u_sqrt_par (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (ce),
        .i_valid (fr_valid),
        .i_val   (fr_mag),
        .o_valid (s1_valid),
        .o_root  (s1_root)
    );

    rvu_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (ce),
        .i_valid (s1_valid),
        .i_root  (s1_root),
        .i_sb    (r_sb1[SQRT_LAT-1]),
        .o_valid (bk_valid),
        .o_l2    (bk_l2),
        .o_sb    (bk_sb)
    );

    rvu_sqrt u_sqrt_len (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (ce),
        .i_valid (bk_valid),
        .i_val   (bk_l2),
        .o_valid (s2_valid),
        .o_root  (s2_root)
    );

    rvu_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (ce),
        .i_valid (s2_valid),
        .i_len   (s2_root),
        .i_sb    (r_sb2[SQRT_LAT-1]),
        .o_valid (dv_valid),
        .o_vec   (dv_vec),
        .o_degen (dv_degen)
    );

    // sideband words ride alongside the square root pipelines
    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_sb1[0] <= fr_sb;
            r_sb2[0] <= bk_sb;
            for (int g = 1; g < SQRT_LAT; g++) begin
                r_sb1[g] <= r_sb1[g-1];
                r_sb2[g] <= r_sb2[g-1];
            end
        end
    end

    assign o_out.valid      = dv_valid;
    assign o_out.out_x      = $signed(dv_vec[0]);
    assign o_out.out_y      = $signed(dv_vec[1]);
    assign o_out.out_z      = $signed(dv_vec[2]);
    assign o_out.degenerate = dv_degen;

    a_degen_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.degenerate |->
            o_out.out_x == 16'sd0 && o_out.out_y == 16'sd0 && o_out.out_z == 16'sd0)
        else $error("degenerate word with nonzero vector");

    a_unit_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && !o_out.degenerate |->
            o_out.out_x <= 16'sd16384 && o_out.out_x >= -16'sd16384 &&
            o_out.out_y <= 16'sd16384 && o_out.out_y >= -16'sd16384 &&
            o_out.out_z <= 16'sd16384 && o_out.out_z >= -16'sd16384)
        else $error("normalized component out of range");

    a_reset_empty : assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out.valid)
        else $error("output valid right after reset");

endmodule

`default_nettype wire
